// File: rtl/core/sha256_byte_stream_hasher_macros.svh
// Assertion macros shared by the hasher checker.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sha_pkg.sv
// Package with SHA-256 constants, round helpers and the controller state type.
package sha_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int LEN_OFFSET  = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_FILL,     // taking message bytes
        ST_PAD,      // writing padding and length bytes
        ST_LOAD,     // loading schedule words from the buffer
        ST_ROUND,    // running the 64 rounds
        ST_UPDATE,   // adding working vars into the hash state
        ST_OUT       // presenting digest words
    } t_state;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        case (i)
            3'd0: init_hash = 32'h6a09e667;
            3'd1: init_hash = 32'hbb67ae85;
            3'd2: init_hash = 32'h3c6ef372;
            3'd3: init_hash = 32'ha54ff53a;
            3'd4: init_hash = 32'h510e527f;
            3'd5: init_hash = 32'h9b05688c;
            3'd6: init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// File: rtl/core/sha256_byte_stream_hasher.sv
// SHA-256 hasher over a byte stream. Bytes go into a 64-byte buffer memory,
// one per accepted item with byte_valid set and at most one per cycle. After
// reset and after every digest the hash memory is loaded with the initial
// values, with s_axis_tready low. A full block is read back as 16 words. It
// is then compressed with one round per cycle in a 16-word sliding schedule.
// The hash state, a small memory, is then updated. The input is stalled
// during these steps, so no byte of the next block is taken before they end.
// On the last item the pad byte, zeros and the length go into the buffer one
// byte a cycle up to the end of the block. When the pad byte lands at position
// 56 or later, a second block of zeros and length follows. Each of these blocks
// is read back, compressed and added in the same way. The eight digest words
// then leave one per accepted output item. The block then reloads the initial
// hash and takes the next message.
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // [0] last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, pad
    output logic        m_axis_tlast    // [0] last_word
);
    import sha_pkg::*;

    // storage
    logic [7:0]  buf_mem [BLOCK_BYTES];
    logic [31:0] hash_mem [8];
    logic [7:0]  buf_rd;
    logic [31:0] hash_rd;

    t_state r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic [63:0] r_len, n_len;
    logic        r_final, n_final;
    logic        r_pend, n_pend;
    logic        r_lenblk, n_lenblk;
    logic [6:0]  r_cnt, n_cnt;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_wacc;
    logic        r_hinit, n_hinit;
    logic [2:0]  r_hidx, n_hidx;

    // buffer and hash memory ports
    logic        buf_we;
    logic [5:0]  buf_wa;
    logic [7:0]  buf_wd;
    logic [5:0]  buf_ra;
    logic        hash_we;
    logic [2:0]  hash_wa, hash_ra;
    logic [31:0] hash_wd;

    logic in_acc, out_acc;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            buf_mem[buf_wa] <= buf_wd;
        end
        buf_rd <= buf_mem[buf_ra];
        if (hash_we) begin
            hash_mem[hash_wa] <= hash_wd;
        end
        hash_rd <= hash_mem[hash_ra];
    end

    // round datapath
    logic [31:0] w_new, t1, t2, s0w, s1w;
    logic [5:0]  rnd;
    assign rnd = r_cnt[5:0];
    always_comb begin
        s0w = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1w = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0w + r_w[9] + s1w;
        t1 = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + ROUND_K[rnd] + r_w[0];
        t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // pad byte for a given fill position: 0x80 first, length only in the final block
    logic [7:0] pad_b;
    logic [2:0] len_sel;
    assign len_sel = r_fill[2:0];
    always_comb begin
        if (!r_final) begin
            pad_b = PAD_BYTE;
        end else if (r_lenblk && r_fill >= 6'(LEN_OFFSET)) begin
            pad_b = r_len[8*(7 - len_sel) +: 8];
        end else begin
            pad_b = 8'h00;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (r_hinit) begin
                    n_state = ST_FILL;
                end else if (in_acc && s_axis_tuser && r_fill == 6'(BLOCK_BYTES - 1)) begin
                    n_state = ST_LOAD;
                end else if (in_acc && s_axis_tlast) begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD:    if (r_fill == 6'(BLOCK_BYTES - 1)) n_state = ST_LOAD;
            ST_LOAD:   if (r_cnt == 7'd64) n_state = ST_ROUND;
            ST_ROUND:  if (r_cnt == 7'd63) n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (r_cnt == 7'd8) begin
                    n_state = !r_pend ? ST_FILL
                            : ((r_final && r_lenblk) ? ST_OUT : ST_PAD);
                end
            end
            ST_OUT:    if (out_acc && r_hidx == 3'd7) n_state = ST_FILL;
            default:   n_state = ST_FILL;
        endcase
    end

    // r_pend: message ended, r_final: pad byte written, r_lenblk: length fits here
    always_comb begin
        n_fill   = r_fill;
        n_bits   = r_bits;
        n_len    = r_len;
        n_final  = r_final;
        n_pend   = r_pend;
        n_lenblk = r_lenblk;
        n_cnt    = r_cnt;
        n_hinit  = r_hinit;
        n_hidx   = r_hidx;
        buf_we   = 1'b0;
        buf_wa   = r_fill;
        buf_wd   = s_axis_tdata;
        buf_ra   = r_cnt[5:0];
        hash_we  = 1'b0;
        hash_wa  = r_hidx;
        hash_wd  = init_hash(r_hidx);
        hash_ra  = r_cnt[2:0];
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_FILL: begin
                if (r_hinit) begin
                    hash_we = 1'b1;
                    n_hidx  = r_hidx + 3'd1;
                    if (r_hidx == 3'd7) n_hinit = 1'b0;
                end else begin
                    s_axis_tready = 1'b1;
                    if (in_acc) begin
                        if (s_axis_tuser) begin
                            buf_we = 1'b1;
                            n_fill = r_fill + 6'd1;
                            n_bits = r_bits + 64'd8;
                        end
                        if (s_axis_tlast) begin
                            n_len   = s_axis_tuser ? r_bits + 64'd8 : r_bits;
                            n_final = 1'b0;
                            n_pend  = 1'b1;
                        end
                        n_cnt = '0;
                    end
                end
            end
            ST_PAD: begin
                buf_we = 1'b1;
                buf_wd = pad_b;
                n_fill = r_fill + 6'd1;
                n_cnt  = '0;
                if (!r_final) begin
                    n_final  = 1'b1;
                    n_lenblk = (r_fill < 6'(LEN_OFFSET));
                end
            end
            ST_LOAD:   n_cnt = (r_cnt == 7'd64) ? 7'd0 : r_cnt + 7'd1;
            ST_ROUND:  n_cnt = (r_cnt == 7'd63) ? 7'd0 : r_cnt + 7'd1;
            ST_UPDATE: begin
                hash_wa = r_cnt[2:0] - 3'd1;
                hash_wd = hash_rd + r_v[r_cnt[2:0] - 3'd1];
                hash_we = (r_cnt != 7'd0);
                n_cnt   = (r_cnt == 7'd8) ? 7'd0 : r_cnt + 7'd1;
                if (r_cnt == 7'd8) begin
                    n_hidx = 3'd0;
                    // the block after a late pad byte carries the length
                    if (r_pend && r_final) n_lenblk = 1'b1;
                end
            end
            ST_OUT: begin
                hash_ra = out_acc ? r_hidx + 3'd1 : r_hidx;
                if (out_acc) begin
                    n_hidx = r_hidx + 3'd1;
                    if (r_hidx == 3'd7) begin
                        n_hinit  = 1'b1;
                        n_fill   = '0;
                        n_bits   = '0;
                        n_final  = 1'b0;
                        n_pend   = 1'b0;
                        n_lenblk = 1'b0;
                        n_len    = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // working variables and schedule window
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_LOAD: begin
                // buffer byte (cnt-1) arrives; pack into words
                if (r_cnt != 7'd0) begin
                    r_wacc <= {r_wacc[23:0], buf_rd};
                    if (r_cnt[1:0] == 2'd0) begin
                        for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                        r_w[15] <= {r_wacc[23:0], buf_rd};
                    end
                end
                if (r_cnt >= 7'd1 && r_cnt <= 7'd8) begin
                    r_v[r_cnt[2:0] - 3'd1] <= hash_rd;
                end
            end
            ST_ROUND: begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                r_w[15] <= w_new;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_FILL;
            r_fill   <= '0;
            r_bits   <= '0;
            r_len    <= '0;
            r_final  <= 1'b0;
            r_pend   <= 1'b0;
            r_lenblk <= 1'b0;
            r_cnt    <= '0;
            r_hinit  <= 1'b1;
            r_hidx   <= '0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_bits   <= n_bits;
            r_len    <= n_len;
            r_final  <= n_final;
            r_pend   <= n_pend;
            r_lenblk <= n_lenblk;
            r_cnt    <= n_cnt;
            r_hinit  <= n_hinit;
            r_hidx   <= n_hidx;
        end
    end

    // output item from hash memory read data
    logic r_ovld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= (n_state == ST_OUT);
        end
    end

    assign m_axis_tvalid = (r_state == ST_OUT) && r_ovld;
    assign m_axis_tdata  = {5'd0, r_hidx, hash_rd};
    assign m_axis_tlast  = (r_hidx == 3'd7);

endmodule

// File: rtl/core/sha_checker.sv
// Port-level checker for the hasher, bound into the hasher module.
`include "sha256_byte_stream_hasher_macros.svh"
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    `SHA_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "input taken during digest output")
    `SHA_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[34:32] == 3'd7), "last flag mismatch")
    `SHA_ASSERT_NXT(a_idx_step, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1, "word index skipped")
    `SHA_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")
endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (.*);

// File: verif/tb.sv
// Self-checking testbench for the SHA-256 byte stream hasher.
module tb;
    import sha_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } t_byte_item;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_item;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] byte_valid
    logic        s_axis_tlast;   // [0] last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] digest_word, [34:32] word_index, pad
    logic        m_axis_tlast;   // [0] last_word

    sha256_byte_stream_hasher dut (.*);

    // Predictor state
    logic [31:0] hash_words [8];
    logic [7:0]  blk_bytes [64];
    logic [5:0]  blk_fill;
    logic [63:0] msg_bits;

    t_byte_item   byte_queue [$];
    t_digest_item digest_queue [$];

    int idle_mode;          // 0: sender 37/recv 54, 1: swapped, 2: none
    bit hold_sender;
    int mismatches;
    int words_seen;
    int messages_done;
    int cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic hash_reset();
        hash_words = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                       32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        blk_fill = '0;
        msg_bits = '0;
    endtask

    task automatic compress_blk();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        v = hash_words;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_words[i] += v[i];
    endtask

    task automatic absorb(logic [7:0] b);
        blk_bytes[blk_fill] = b;
        blk_fill++;
        if (blk_fill == 0)
            compress_blk();
    endtask

    // Apply one accepted byte item to the predictor
    task automatic predict_digest(t_byte_item it);
        logic [63:0] len;
        if (it.valid) begin
            msg_bits += 64'd8;
            absorb(it.data);
        end
        if (!it.last)
            return;
        len = msg_bits;
        absorb(PAD_BYTE);
        while (blk_fill != 6'(LEN_OFFSET))
            absorb(8'h00);
        for (int i = 0; i < 8; i++)
            absorb(len[63-8*i -: 8]);
        for (int i = 0; i < 8; i++)
            digest_queue.push_back('{hash_words[i], 3'(i), i == 7});
        hash_reset();
    endtask

    task automatic push_msg(int len, bit empty_finish);
        for (int i = 0; i < len; i++)
            byte_queue.push_back('{8'($urandom), 1'b1, !empty_finish && i == len - 1});
        if (empty_finish || len == 0)
            byte_queue.push_back('{8'($urandom), 1'b0, 1'b1});
    endtask

    // Wait until every item is taken and every expected word has come
    task automatic drain();
        while (byte_queue.size() != 0 || s_axis_tvalid || digest_queue.size() != 0)
            @(posedge i_clk);
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (byte_queue.size() > 0 && !hold_sender
                && !(idle_mode == 0 && $urandom_range(99) < 37)
                && !(idle_mode == 1 && $urandom_range(99) < 54)) begin
                t_byte_item it;
                it = byte_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= it.data;
                s_axis_tuser  <= it.valid;
                s_axis_tlast  <= it.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        if (i_rst_n)
            m_axis_tready <= !((idle_mode == 0 && $urandom_range(99) < 54)
                            || (idle_mode == 1 && $urandom_range(99) < 37));
    end

    // Monitor: inputs feed the predictor, outputs are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                predict_digest('{s_axis_tdata, s_axis_tuser, s_axis_tlast});
            if (m_axis_tvalid && m_axis_tready) begin
                t_digest_item got, exp_item;
                got = '{m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast};
                words_seen++;
                if (digest_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest word %h idx %0d", got.word, got.idx);
                end else begin
                    exp_item = digest_queue.pop_front();
                    if (got !== exp_item) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     exp_item.word, exp_item.idx, exp_item.last,
                                     got.word, got.idx, got.last);
                    end
                    if (got.last)
                        messages_done++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("sha256_byte_stream_hasher verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        idle_mode = 0;
        hold_sender = 1'b0;
        mismatches = 0;
        words_seen = 0;
        messages_done = 0;
        cycles = 0;
        hash_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, idle items, one-byte extremes, "abc"
        byte_queue.push_back('{8'h00, 1'b0, 1'b0});
        byte_queue.push_back('{8'hff, 1'b0, 1'b1});
        byte_queue.push_back('{8'h00, 1'b1, 1'b1});
        byte_queue.push_back('{8'hff, 1'b1, 1'b0});
        byte_queue.push_back('{8'h55, 1'b0, 1'b0});
        byte_queue.push_back('{8'haa, 1'b0, 1'b1});
        byte_queue.push_back('{8'h61, 1'b1, 1'b0});
        byte_queue.push_back('{8'h62, 1'b1, 1'b0});
        byte_queue.push_back('{8'h63, 1'b1, 1'b1});

        // Let everything drain before the random part
        drain();

        // Random: lengths around padding boundaries and full blocks, plus empty and short messages
        for (int phase = 0; phase < 3; phase++) begin
            idle_mode = phase;
            while (byte_queue.size() < 56) begin
                case ($urandom_range(5))
                    0: push_msg($urandom_range(55, 57), 1'($urandom_range(1)));
                    1: push_msg($urandom_range(63, 65), 1'($urandom_range(1)));
                    2: push_msg(0, 1'b1);
                    default: push_msg($urandom_range(1, 20), 1'($urandom_range(1)));
                endcase
                if ($urandom_range(3) == 0)
                    byte_queue.push_back('{8'($urandom), 1'b0, 1'b0});
            end
            // In the first phase, pause the sender with items pending until all results are out
            if (phase == 0) begin
                repeat (150) @(posedge i_clk);
                hold_sender = 1'b1;
                while (s_axis_tvalid || digest_queue.size() != 0)
                    @(posedge i_clk);
                repeat (20) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("checked %0d digest words over %0d messages, empty and block-boundary cases",
                 words_seen, messages_done);
        if (mismatches == 0 && digest_queue.size() == 0)
            $display("sha256_byte_stream_hasher verification clean");
        else
            $display("sha256_byte_stream_hasher verification failed");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/sha_pkg.sv
rtl/core/sha256_byte_stream_hasher.sv
rtl/core/sha_checker.sv
verif/tb.sv
